// ----- rtl/i2sd_pkg.sv -----
package i2sd_pkg;

	localparam int NUMBER_W = 27;
	localparam int SEG_W    = 7;
	localparam int POS_W    = 3;
	localparam int CNT_W    = 4;
	localparam int DIGIT_W  = 4;
	localparam int POW_W    = 35;
	localparam int RECIP_W  = 32;
	localparam int RECIP_SH = 35;

	localparam logic [CNT_W-1:0]   DIGIT_COUNT_RST = 4'd4;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE      = 4'd9;
	// floor(x / 10) == (x * RECIP_TEN) >> RECIP_SH for any x below 2^32
	localparam logic [RECIP_W-1:0] RECIP_TEN       = 32'hCCCC_CCCD;

	// request handed from the front to the converter
	typedef struct packed {
		logic [NUMBER_W-1:0] number;
		logic [CNT_W-1:0]    count;
		logic                sat;
	} conv_req_t;

	// control that travels with a converted digit set
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             sat;
	} digit_info_t;

	function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] p;
		case (d)
			4'd0:    p = 7'h3f;
			4'd1:    p = 7'h06;
			4'd2:    p = 7'h5b;
			4'd3:    p = 7'h4f;
			4'd4:    p = 7'h66;
			4'd5:    p = 7'h6d;
			4'd6:    p = 7'h7d;
			4'd7:    p = 7'h07;
			4'd8:    p = 7'h7f;
			4'd9:    p = 7'h67;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

	function automatic logic [POW_W-1:0] pow10(input logic [CNT_W-1:0] n);
		logic [POW_W-1:0] p;
		case (n)
			4'd0:    p = 35'd1;
			4'd1:    p = 35'd10;
			4'd2:    p = 35'd100;
			4'd3:    p = 35'd1000;
			4'd4:    p = 35'd10000;
			4'd5:    p = 35'd100000;
			4'd6:    p = 35'd1000000;
			4'd7:    p = 35'd10000000;
			4'd8:    p = 35'd100000000;
			4'd9:    p = 35'd1000000000;
			4'd10:   p = 35'd10000000000;
			default: p = {POW_W{1'b1}};
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/i2sd_front.sv -----
module i2sd_front import i2sd_pkg::*; #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    digit_count,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [NUMBER_W-1:0] number,
	input  logic                q_ready,
	output logic                q_valid,
	output conv_req_t           q_req
);

	logic [CNT_W-1:0] digit_count_q;
	logic [CNT_W-1:0] cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= DIGIT_COUNT_RST;
		end else if (cfg_valid) begin
			digit_count_q <= digit_count;
		end
	end

	// zero means one digit; anything past the display width is clamped
	always_comb begin
		if (digit_count_q == '0) begin
			cnt = CNT_W'(1);
		end else if (digit_count_q > CNT_W'(MAX_DIGITS)) begin
			cnt = CNT_W'(MAX_DIGITS);
		end else begin
			cnt = digit_count_q;
		end
	end

	assign in_ready      = q_ready;
	assign q_valid       = in_valid;
	assign q_req.number  = number;
	assign q_req.count   = cnt;
	assign q_req.sat     = ({(POW_W-NUMBER_W)'(0), number} >= pow10(cnt));

endmodule

// ----- rtl/i2sd_queue.sv -----
module i2sd_queue import i2sd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  conv_req_t in_req,
	output logic      out_valid,
	input  logic      out_ready,
	output conv_req_t out_req
);

	conv_req_t  ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_req   = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- rtl/i2sd_conv.sv -----
module i2sd_conv import i2sd_pkg::*; #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  conv_req_t                           req,
	output logic                                dig_valid,
	input  logic                                dig_ready,
	output logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits,
	output digit_info_t                         info
);

	localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int PROD_W = NUMBER_W + RECIP_W;
	localparam int QUO_W  = PROD_W - RECIP_SH;

	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [NUMBER_W-1:0] x_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                sat_q;
	logic                busy_q;
	logic                done_q;

	logic [PROD_W-1:0]   prod;
	logic [QUO_W-1:0]    quo;
	logic [DIGIT_W-1:0]  ten_q_lo;
	logic [DIGIT_W-1:0]  dig;
	logic                take;

	// x / 10 by reciprocal; the digit only needs the low nibble of x - 10*q
	assign prod     = PROD_W'(x_q) * PROD_W'(RECIP_TEN);
	assign quo      = prod[PROD_W-1:RECIP_SH];
	assign ten_q_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
	assign dig      = x_q[DIGIT_W-1:0] - ten_q_lo;

	assign take      = done_q && dig_ready;
	assign req_ready = !busy_q && (!done_q || dig_ready);
	assign dig_valid = done_q;
	assign digits    = digits_q;
	assign info.count = cnt_q;
	assign info.sat   = sat_q;

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			x_q   <= req.number;
			cnt_q <= req.count;
			sat_q <= req.sat;
			rem_q <= req.count - CNT_W'(1);
			idx_q <= '0;
		end else if (busy_q) begin
			digits_q[idx_q] <= dig;
			x_q   <= NUMBER_W'(quo);
			rem_q <= rem_q - CNT_W'(1);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (take) begin
				done_q <= 1'b0;
			end
			if (req_valid && req_ready) begin
				busy_q <= 1'b1;
			end else if (busy_q && rem_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (CNT_W'(idx_q) < cnt_q))
		else $error("digit index ran past the digit count");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("converter busy while holding a finished digit set");

endmodule

// ----- rtl/i2sd_emit.sv -----
module i2sd_emit import i2sd_pkg::*; #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                dig_valid,
	output logic                                dig_ready,
	input  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits,
	input  digit_info_t                         info,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [SEG_W-1:0]                    segments,
	output logic [POS_W-1:0]                    digit_position,
	output logic                                is_last
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [IDX_W-1:0]   w_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   count_q;
	logic               sat_q;
	logic               seen_q;
	logic               busy_q;
	logic               valid_q;
	logic [SEG_W-1:0]   seg_q;
	logic [POS_W-1:0]   dpos_q;
	logic               last_q;

	logic               step;
	logic               load;
	logic [DIGIT_W-1:0] d;
	logic               show;

	assign step      = busy_q && (!valid_q || out_ready);
	assign dig_ready = !busy_q || (step && w_q == '0);
	assign load      = dig_valid && dig_ready;

	// saturated numbers show nine everywhere; blank zeros until the first nonzero
	assign d    = sat_q ? DIGIT_NINE : digits_q[w_q];
	assign show = (d != '0) || seen_q || (w_q == '0);

	assign out_valid      = valid_q;
	assign segments       = seg_q;
	assign digit_position = dpos_q;
	assign is_last        = last_q;

	always_ff @(posedge clk) begin
		if (step) begin
			seg_q  <= show ? seg_font(d) : '0;
			dpos_q <= pos_q[POS_W-1:0];
			last_q <= (w_q == '0);
		end
		if (load) begin
			digits_q <= digits;
			count_q  <= info.count;
			sat_q    <= info.sat;
			w_q      <= IDX_W'(info.count - CNT_W'(1));
			pos_q    <= '0;
		end else if (step) begin
			w_q   <= w_q - IDX_W'(1);
			pos_q <= pos_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			seen_q  <= 1'b0;
		end else begin
			if (step) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
				seen_q <= 1'b0;
			end else if (step) begin
				seen_q <= seen_q || (d != '0);
				if (w_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (CNT_W'(w_q) < count_q))
		else $error("digit weight outside the digit count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (seg_q != '0))
		else $error("least significant digit was blanked");

endmodule

// ----- rtl/integer_to_seven_segment_digits.sv -----
// Path: the first digit of a number passes through the queue, the converter load,
// one divide-by-ten per digit, the emitter load and the output register.
// Throughput: one digit per cycle within a number while out_ready is high; the converter
// loop retires one decimal digit per cycle and takes no new number until the last is done.
// Reset: clears all handshake state and sets the digit count to 4.
module integer_to_seven_segment_digits import i2sd_pkg::*; #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    digit_count,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [NUMBER_W-1:0] number,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SEG_W-1:0]    segments,
	output logic [POS_W-1:0]    digit_position,
	output logic                is_last
);

	logic        fq_valid;
	logic        fq_ready;
	conv_req_t   fq_req;
	logic        qc_valid;
	logic        qc_ready;
	conv_req_t   qc_req;
	logic        ce_valid;
	logic        ce_ready;
	digit_info_t ce_info;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] ce_digits;

	i2sd_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.digit_count (digit_count),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.number      (number),
		.q_ready     (fq_ready),
		.q_valid     (fq_valid),
		.q_req       (fq_req)
	);

	i2sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_req    (fq_req),
		.out_valid (qc_valid),
		.out_ready (qc_ready),
		.out_req   (qc_req)
	);

	i2sd_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (qc_valid),
		.req_ready (qc_ready),
		.req       (qc_req),
		.dig_valid (ce_valid),
		.dig_ready (ce_ready),
		.digits    (ce_digits),
		.info      (ce_info)
	);

	i2sd_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.dig_valid      (ce_valid),
		.dig_ready      (ce_ready),
		.digits         (ce_digits),
		.info           (ce_info),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segments       (segments),
		.digit_position (digit_position),
		.is_last        (is_last)
	);

endmodule
